/* hw/rtl/indexed_list_engine_defines.svh */
// Assertion macros for the indexed list engine checker.
`ifndef INDEXED_LIST_ENGINE_DEFINES_SVH
`define INDEXED_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ILE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ILE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/ile_pkg.sv */
// Shared types and codes of the indexed list engine.
`timescale 1ns / 1ps

package ile_pkg;

    localparam int OPCODE_W = 3;
    localparam int POS_W    = 10;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    localparam logic [OPCODE_W-1:0] OP_APPEND       = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_WRITE        = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_READ         = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_REMOVE_AT    = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_REMOVE_FIRST = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_REMOVE_ALL   = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [POS_W-1:0]    position;
        logic [DATA_W-1:0]   item_value;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0]   read_value;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  entry_count;
        logic [COUNT_W-1:0]  removed_count;
    } rsp_t;

endpackage

/* hw/rtl/ile_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ile_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hw/rtl/indexed_list_engine.sv */
// Indexed list engine: a list of value words in RAM with a held count.
// One request is taken at a time and gives exactly one response. Append, write
// and out-of-range requests go through S_EXEC and S_EMIT, a read through S_EXEC,
// S_RDWAIT and S_EMIT. Remove at index, remove first match and remove all matches
// walk the RAM in S_SCAN from the start point (the index, or entry 0) to the
// end of the list, one read and at most one write-back per cycle, a rate set
// by the single read port of the entry RAM. The next request is taken as soon
// as the engine is idle, even while the previous response still waits in the
// output register. The RAM needs no clearing after reset: only entries below
// the count are ever read.
`timescale 1ns / 1ps

module indexed_list_engine #(
    parameter int CAPACITY   = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ile_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ile_pkg::rsp_t rsp
);

    localparam int AW        = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int CMP_W     = (CNT_W > ile_pkg::POS_W) ? CNT_W : ile_pkg::POS_W;
    localparam int OUT_VAL_W = ile_pkg::DATA_W;
    localparam int OUT_CNT_W = ile_pkg::COUNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_SCAN,
        S_EMIT
    } state_t;

    state_t                          state_reg, state_next;
    ile_pkg::req_t                   req_reg, req_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [CNT_W-1:0]                rd_idx_reg, rd_idx_next;
    logic                            s2_valid_reg, s2_valid_next;
    logic [CNT_W-1:0]                s2_idx_reg, s2_idx_next;
    logic [CNT_W-1:0]                removed_reg, removed_next;
    logic [ile_pkg::STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [VALUE_BITS-1:0]           res_read_reg, res_read_next;
    logic                            rsp_valid_reg, rsp_valid_next;
    ile_pkg::rsp_t                   rsp_reg, rsp_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [VALUE_BITS-1:0] ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [VALUE_BITS-1:0] ram_rdata;

    logic [VALUE_BITS-1:0] op_val;
    logic                  in_range;
    logic                  s2_hit;
    logic [CNT_W-1:0]      wr_idx;

    ile_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign op_val   = VALUE_BITS'(req_reg.item_value);
    assign in_range = CMP_W'(req_reg.position) < CMP_W'(count_reg);
    assign wr_idx   = s2_idx_reg - removed_reg;

    // Drop the entry at the index, the first match, or every match.
    assign s2_hit = s2_valid_reg &&
                    ((req_reg.opcode == ile_pkg::OP_REMOVE_AT) ?
                        (s2_idx_reg == CNT_W'(req_reg.position)) :
                        ((ram_rdata == op_val) &&
                         ((req_reg.opcode == ile_pkg::OP_REMOVE_ALL) ||
                          (removed_reg == '0))));

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        s2_valid_next   = s2_valid_reg;
        s2_idx_next     = s2_idx_reg;
        removed_next    = removed_reg;
        res_status_next = res_status_reg;
        res_read_next   = res_read_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = op_val;
        ram_re          = 1'b0;
        ram_raddr       = '0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_status_next = ile_pkg::ST_OK;
                res_read_next   = '0;
                removed_next    = '0;
                rd_idx_next     = '0;
                s2_valid_next   = 1'b0;
                state_next      = S_EMIT;
                case (req_reg.opcode)
                    ile_pkg::OP_APPEND:
                    begin
                        if (count_reg == CNT_W'(CAPACITY))
                        begin
                            res_status_next = ile_pkg::ST_FULL;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = count_reg[AW-1:0];
                            count_next = count_reg + 1'b1;
                        end
                    end
                    ile_pkg::OP_WRITE:
                    begin
                        if (!in_range)
                        begin
                            res_status_next = ile_pkg::ST_RANGE;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = AW'(req_reg.position);
                        end
                    end
                    ile_pkg::OP_READ:
                    begin
                        if (!in_range)
                        begin
                            res_status_next = ile_pkg::ST_RANGE;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = AW'(req_reg.position);
                            state_next = S_RDWAIT;
                        end
                    end
                    ile_pkg::OP_REMOVE_AT:
                    begin
                        if (!in_range)
                        begin
                            res_status_next = ile_pkg::ST_RANGE;
                        end
                        else
                        begin
                            rd_idx_next = CNT_W'(req_reg.position);
                            state_next  = S_SCAN;
                        end
                    end
                    ile_pkg::OP_REMOVE_FIRST,
                    ile_pkg::OP_REMOVE_ALL:
                    begin
                        state_next = S_SCAN;
                    end
                    default:
                    begin
                    end
                endcase
            end

            S_RDWAIT:
            begin
                res_read_next = ram_rdata;
                state_next    = S_EMIT;
            end

            S_SCAN:
            begin
                // Read stage: fetch the next entry while one is left.
                if (rd_idx_reg != count_reg)
                begin
                    ram_re        = 1'b1;
                    ram_raddr     = rd_idx_reg[AW-1:0];
                    rd_idx_next   = rd_idx_reg + 1'b1;
                    s2_valid_next = 1'b1;
                    s2_idx_next   = rd_idx_reg;
                end
                else
                begin
                    s2_valid_next = 1'b0;
                end

                // Write-back stage: writes land below the read pointer, so no hazard.
                if (s2_hit)
                begin
                    removed_next = removed_reg + 1'b1;
                end
                else if (s2_valid_reg && (removed_reg != '0))
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wr_idx[AW-1:0];
                    ram_wdata = ram_rdata;
                end

                if ((rd_idx_reg == count_reg) && !s2_valid_reg)
                begin
                    count_next = count_reg - removed_reg;
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                // Hold the result until the output register is free.
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.read_value    = OUT_VAL_W'(res_read_reg);
                    rsp_next.status        = res_status_reg;
                    rsp_next.entry_count   = OUT_CNT_W'(count_reg);
                    rsp_next.removed_count = OUT_CNT_W'(removed_reg);
                    rsp_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            req_reg        <= '0;
            count_reg      <= '0;
            rd_idx_reg     <= '0;
            s2_valid_reg   <= 1'b0;
            s2_idx_reg     <= '0;
            removed_reg    <= '0;
            res_status_reg <= ile_pkg::ST_OK;
            res_read_reg   <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            req_reg        <= req_next;
            count_reg      <= count_next;
            rd_idx_reg     <= rd_idx_next;
            s2_valid_reg   <= s2_valid_next;
            s2_idx_reg     <= s2_idx_next;
            removed_reg    <= removed_next;
            res_status_reg <= res_status_next;
            res_read_reg   <= res_read_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_reg        <= rsp_next;
        end
    end

endmodule

/* hw/rtl/ile_checker.sv */
// Port-level checker for the indexed list engine, bound into indexed_list_engine.
`timescale 1ns / 1ps
`include "indexed_list_engine_defines.svh"

module ile_checker #(
    parameter int CAPACITY = 1024
) (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input ile_pkg::rsp_t rsp
);

    localparam int OUT_CNT_W = ile_pkg::COUNT_W;

    // Requests taken but not yet answered: one in flight, one in the output register.
    logic [1:0] pending_reg, pending_next;

    always_comb
    begin
        pending_next = pending_reg;
        if ((req_valid && req_ready) && !(rsp_valid && rsp_ready))
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (!(req_valid && req_ready) && (rsp_valid && rsp_ready))
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `ILE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "response dropped or changed while stalled")
    `ILE_ASSERT_NOW(a_rsp_has_req, rsp_valid, (pending_reg == 2'd1) || (pending_reg == 2'd2), "response without a matching request")
    `ILE_ASSERT_NOW(a_err_clean, rsp_valid && (rsp.status != ile_pkg::ST_OK), (rsp.read_value == '0) && (rsp.removed_count == '0), "failed request reports data or removals")
    `ILE_ASSERT_NOW(a_full_count, rsp_valid && (rsp.status == ile_pkg::ST_FULL), rsp.entry_count == OUT_CNT_W'(CAPACITY), "full status with a count below capacity")

endmodule

bind indexed_list_engine ile_checker #(
    .CAPACITY (CAPACITY)
) u_ile_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
